/* rtl/core/turtle_vector_command_engine_top_defines.svh */
// Assertion macros used by the turtle engine checker.
`ifndef TURTLE_VECTOR_COMMAND_ENGINE_TOP_DEFINES_SVH
`define TURTLE_VECTOR_COMMAND_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TVCE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define TVCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/tvce_pkg.sv */
// Shared types, widths and codes of the turtle vector command engine.
`timescale 1ns / 1ps
package tvce_pkg;

	localparam int COORD_W         = 24;
	localparam int ANGLE_W         = 16;
	localparam int FUNC_W          = 3;
	localparam int SINE_W          = 16;   // table entries 0..32768
	localparam int TRIG_W          = SINE_W + 1;
	localparam int CFG_IDX_W       = 1;
	localparam int S_TDATA_W       = 96;
	localparam int M_TDATA_W       = 96;
	localparam int SINE_ENTRIES_DEF = 1024;
	localparam int COORD_FRAC_BITS = 8;

	// command codes
	localparam logic [FUNC_W-1:0] FUNC_SET_HEADING = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_TURN        = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_MOVE_TO     = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_LINE_TO     = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_FORWARD     = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [ANGLE_W-1:0]        angle_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		angle_t            angle;
		coord_t            x;
		coord_t            y;
		coord_t            dist_req;
		logic              visible;
	} cmd_t;

	// home position, whole units scaled to Q16.8 and clipped to the coordinate range
	localparam longint HOME_X_UNITS = 225;
	localparam longint HOME_Y_UNITS = 200;
	localparam longint COORD_MAX    = 64'sd8388607;
	localparam longint HOME_X_RAW   = HOME_X_UNITS * (64'sd1 <<< COORD_FRAC_BITS);
	localparam longint HOME_Y_RAW   = HOME_Y_UNITS * (64'sd1 <<< COORD_FRAC_BITS);
	localparam coord_t HOME_X = (HOME_X_RAW > COORD_MAX) ? 24'sh7FFFFF : COORD_W'(HOME_X_RAW);
	localparam coord_t HOME_Y = (HOME_Y_RAW > COORD_MAX) ? 24'sh7FFFFF : COORD_W'(HOME_Y_RAW);

endpackage

/* rtl/core/turtle_vector_command_engine_top.sv */
// Turtle vector command engine: pen/heading state, sine lookup and segment output.
//
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tdata: command operands, tuser: func
//  m_*      out  tvalid/tready      tdata: segment x0 y0 x1 y1
//  cfg_*    in   cfg_wen (no wait)  cfg_idx, cfg_wdata: start_x / start_y
//
// One item per cycle unless s_tready drops; a segment passes the input stage, then the result register.
// The pen/heading update of an item is registered as it leaves the input stage, so the next item sees it.
// The sin/cos registers follow the heading through a registered table read.
// s_tready drops only when a drawing item waits on a full output register.
// Reset puts the pen home and the heading at zero; a start write reloads the pen.
`timescale 1ns / 1ps
module turtle_vector_command_engine_top #(
	parameter int SINE_ENTRIES = tvce_pkg::SINE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// angle_value[15:0], x_value[39:16], y_value[63:40], dist_req[87:64],
	// visible[88], zero[95:89]
	input  logic [tvce_pkg::S_TDATA_W-1:0]   s_tdata,
	// func[2:0]
	input  logic [tvce_pkg::FUNC_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// seg_x0[23:0], seg_y0[47:24], seg_x1[71:48], seg_y1[95:72]
	output logic [tvce_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                             cfg_wen,
	input  logic [tvce_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [tvce_pkg::COORD_W-1:0]     cfg_wdata
);
	import tvce_pkg::*;

	localparam int ADDR_W  = $clog2(SINE_ENTRIES + 1);
	localparam int OFS_W   = 14;
	localparam int PROD_W  = COORD_W + TRIG_W;
	localparam int STEP_W  = PROD_W - 15;
	localparam int SUM_W   = STEP_W + 1;
	localparam angle_t QUARTER = 16'h4000;

	// quarter-wave sine table, Taylor series in Q2.30 worked out at elaboration
	logic [SINE_W-1:0] sine_rom [0:SINE_ENTRIES];

	for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_rom
		localparam logic [63:0] X   = (64'd1686629713 * 64'(k)) / SINE_ENTRIES;
		localparam logic [63:0] X2  = (X * X) >> 30;
		localparam logic [63:0] T1  = ((X * X2) >> 30) / 64'd6;
		localparam logic [63:0] T2  = ((T1 * X2) >> 30) / 64'd20;
		localparam logic [63:0] T3  = ((T2 * X2) >> 30) / 64'd42;
		localparam logic [63:0] T4  = ((T3 * X2) >> 30) / 64'd72;
		localparam logic [63:0] T5  = ((T4 * X2) >> 30) / 64'd110;
		localparam logic [63:0] T6  = ((T5 * X2) >> 30) / 64'd156;
		localparam logic signed [63:0] SUM = $signed(X) - $signed(T1) + $signed(T2)
			- $signed(T3) + $signed(T4) - $signed(T5) + $signed(T6);
		localparam logic [63:0] POS = (SUM < 0) ? 64'd0 : 64'(SUM);
		localparam logic [63:0] ENT = (POS + 64'd16384) >> 15;
		assign sine_rom[k] = ENT[SINE_W-1:0];
	end

	// table address and sign for an angle: {negate, address}
	function automatic logic [ADDR_W:0] trig_addr(input angle_t a);
		logic [OFS_W+ADDR_W-1:0] prod;
		logic [ADDR_W-1:0]       idx;
		prod = (OFS_W + ADDR_W)'(a[OFS_W-1:0]) * (OFS_W + ADDR_W)'(SINE_ENTRIES);
		idx  = prod[OFS_W +: ADDR_W];
		if (a[OFS_W])
			idx = ADDR_W'(SINE_ENTRIES) - idx;
		return {a[OFS_W+1], idx};
	endfunction

	function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(signed'(24'sh7FFFFF)))
			return 24'sh7FFFFF;
		if (v < SUM_W'(signed'(24'sh800000)))
			return 24'sh800000;
		return v[COORD_W-1:0];
	endfunction

	// input stage
	logic   v_s1;
	cmd_t   cmd_s1;
	logic   draw_s1;
	logic   adv;
	logic   in_acc;

	// architectural state
	coord_t pen_x_q, pen_y_q;
	angle_t heading_q;
	logic signed [TRIG_W-1:0] sin_q, cos_q;

	// result register
	logic                   out_v_q;
	logic [M_TDATA_W-1:0]   out_data_q;

	// next-state logic
	angle_t heading_nx, heading_d, cos_ang;
	coord_t pen_x_nx, pen_y_nx;
	logic signed [PROD_W-1:0] prod_x, prod_y;
	logic signed [STEP_W-1:0] step_x, step_y;
	logic [ADDR_W:0] sin_sel, cos_sel;

	assign draw_s1  = (cmd_s1.func == FUNC_LINE_TO) ||
		((cmd_s1.func == FUNC_FORWARD) && cmd_s1.visible);
	assign adv      = v_s1 && (!draw_s1 || !out_v_q || m_tready);
	assign s_tready = !v_s1 || adv;
	assign in_acc   = s_tvalid && s_tready;

	assign prod_x = PROD_W'(cmd_s1.dist_req) * PROD_W'(cos_q);
	assign prod_y = PROD_W'(cmd_s1.dist_req) * PROD_W'(sin_q);
	// round half up, then floor
	assign step_x = STEP_W'((prod_x + PROD_W'(16384)) >>> 15);
	assign step_y = STEP_W'((prod_y + PROD_W'(16384)) >>> 15);

	always_comb begin
		heading_nx = heading_q;
		pen_x_nx   = pen_x_q;
		pen_y_nx   = pen_y_q;
		unique case (cmd_s1.func)
			FUNC_SET_HEADING: heading_nx = cmd_s1.angle;
			FUNC_TURN:        heading_nx = heading_q + cmd_s1.angle;
			FUNC_MOVE_TO, FUNC_LINE_TO: begin
				pen_x_nx = cmd_s1.x;
				pen_y_nx = cmd_s1.y;
			end
			FUNC_FORWARD: begin
				pen_x_nx = sat_coord(SUM_W'(pen_x_q) + SUM_W'(step_x));
				pen_y_nx = sat_coord(SUM_W'(pen_y_q) + SUM_W'(step_y));
			end
			default: ;
		endcase
	end

	// sin/cos track the heading that holds after this edge
	assign heading_d = adv ? heading_nx : heading_q;
	assign cos_ang   = heading_d + QUARTER;
	assign sin_sel   = trig_addr(heading_d);
	assign cos_sel   = trig_addr(cos_ang);

	always_ff @(posedge clk) begin
		sin_q <= sin_sel[ADDR_W] ? -$signed({1'b0, sine_rom[sin_sel[ADDR_W-1:0]]})
			: $signed({1'b0, sine_rom[sin_sel[ADDR_W-1:0]]});
		cos_q <= cos_sel[ADDR_W] ? -$signed({1'b0, sine_rom[cos_sel[ADDR_W-1:0]]})
			: $signed({1'b0, sine_rom[cos_sel[ADDR_W-1:0]]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1.func     <= s_tuser;
			cmd_s1.angle    <= s_tdata[15:0];
			cmd_s1.x        <= s_tdata[39:16];
			cmd_s1.y        <= s_tdata[63:40];
			cmd_s1.dist_req <= s_tdata[87:64];
			cmd_s1.visible  <= s_tdata[88];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q   <= HOME_X;
			pen_y_q   <= HOME_Y;
			heading_q <= '0;
		end else begin
			if (adv) begin
				pen_x_q   <= pen_x_nx;
				pen_y_q   <= pen_y_nx;
				heading_q <= heading_nx;
			end
			// home load; the user must write it only while no item is in flight, the block does not enforce it
			if (cfg_wen) begin
				unique case (cfg_idx)
					REG_START_X: pen_x_q <= cfg_wdata;
					REG_START_Y: pen_y_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && draw_s1) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && draw_s1)
			out_data_q <= {pen_y_nx, pen_x_nx, pen_y_q, pen_x_q};
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;

endmodule

/* rtl/core/tvce_checker.sv */
// Port-level assertions for the turtle vector command engine, bound to the top.
`timescale 1ns / 1ps
`include "turtle_vector_command_engine_top_defines.svh"
module tvce_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [tvce_pkg::M_TDATA_W-1:0] m_tdata
);

	// a stalled segment holds
	`TVCE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "segment dropped or changed while stalled")

	// a fresh segment follows an item taken before it, through the input stage and the result register
	`TVCE_ASSERT_IMPL(a_rise_after_accept, clk, arst_n, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "segment appeared with no item taken")

	// input backpressure only comes from a full, stalled output
	`TVCE_ASSERT_IMPL(a_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready, "input stalled while output is free")

endmodule

bind turtle_vector_command_engine_top tvce_checker u_tvce_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
